/* hdl/etf_pkg.sv */
// ----------------------------------------------------------------------------
// etf_pkg - shared definitions for the EtherType filtered frame FIFO
// Status codes, filter constants and default geometry of the frame ring.
// ----------------------------------------------------------------------------
package etf_pkg;

    // default ring geometry
    localparam int C_SLOTS      = 10;
    localparam int C_SLOT_BYTES = 1024;

    // stream payload widths
    localparam int C_BYTE_W   = 8;
    localparam int C_FLEN_W   = 11;
    localparam int C_STAT_W   = 3;
    localparam int C_S_DATA_W = 24;   // rx_byte, read_limit, zero fill
    localparam int C_M_DATA_W = 24;   // data_byte, frame_length, zero fill

    // filter constants
    localparam logic [7:0] C_TYPE_HI   = 8'h88;
    localparam logic [7:0] C_TYPE_LO   = 8'hA4;
    localparam int         C_MIN_FRAME = 14;
    localparam int         C_TYPE_POS  = 12;

    // command codes
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    typedef logic [C_STAT_W-1:0] t_status;
    localparam t_status ST_TAKEN    = 3'd0;
    localparam t_status ST_STORED   = 3'd1;
    localparam t_status ST_FILTERED = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_OVERSIZE = 3'd4;
    localparam t_status ST_READ     = 3'd5;
    localparam t_status ST_EMPTY    = 3'd6;

endpackage

/* hdl/ethertype_filtered_frame_fifo_core.sv */
// ----------------------------------------------------------------------------
// ethertype_filtered_frame_fifo_core - receive frame ring with EtherType filter
// Stores received frames of type 0x88A4 into a ring of slots and plays them
// back byte by byte on read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per command. tuser = cmd (0 receive byte, 1 read).
//   Receive beats carry the frame byte in tdata and tlast on the final byte.
//   Read beats carry the caller buffer size in tdata; it is sampled on the
//   first byte of each frame read.
//   Master stream: exactly one beat per slave beat, in order. tuser = status,
//   tdata = data byte and frame length, tlast = last delivered frame byte.
// Timing:
//   A beat is accepted, the frame and length memories are read on that edge,
//   and the result is registered in the update state that follows, unless
//   a held result stalls it. A new beat is accepted only after the update,
//   which waits for the registered read of the frame memory.
// Reset:
//   Ring is empty, all counters zero. Memories are not cleared; only slots
//   that were committed are ever read back.
// Stall:
//   The result register holds while m_axis_tready is low. One more beat can
//   be accepted meanwhile; the block then waits in its update cycle with
//   s_axis_tready low until the held result moves.
// ----------------------------------------------------------------------------
module ethertype_filtered_frame_fifo_core #(
    parameter int SLOTS      = etf_pkg::C_SLOTS,
    parameter int SLOT_BYTES = etf_pkg::C_SLOT_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave: [7:0] rx_byte, [18:8] read_limit, [23:19] zero
    input  logic [etf_pkg::C_S_DATA_W-1:0] s_axis_tdata,
    // slave: [0] cmd
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,   // rx_last
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // master: [7:0] data_byte, [18:8] frame_length, [23:19] zero
    output logic [etf_pkg::C_M_DATA_W-1:0] m_axis_tdata,
    // master: [2:0] status
    output logic [etf_pkg::C_STAT_W-1:0]   m_axis_tuser,
    output logic                           m_axis_tlast,   // last_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    import etf_pkg::*;

    localparam int SLW   = $clog2(SLOTS);
    localparam int AW    = $clog2(SLOTS * SLOT_BYTES);
    localparam int OFFW  = $clog2(SLOT_BYTES + 2);   // write offset saturates at SLOT_BYTES+1
    localparam int LENW  = $clog2(SLOT_BYTES + 1);
    localparam int CMPW  = (LENW > C_FLEN_W) ? LENW : C_FLEN_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // control state
    logic             r_state;
    logic [SLW-1:0]   r_head, r_tail;
    logic [AW-1:0]    r_head_base, r_tail_base;
    logic             r_full;
    logic [OFFW-1:0]  r_wr_off;
    logic             r_type_match;
    logic             r_lost;
    logic [LENW-1:0]  r_rd_off;
    logic [LENW-1:0]  r_rd_total;
    logic             r_out_valid;

    // captured beat and result payload
    logic                r_in_cmd;
    logic [C_BYTE_W-1:0] r_in_byte;
    logic                r_in_last;
    logic [C_FLEN_W-1:0] r_in_limit;
    t_status             r_out_status;
    logic [C_BYTE_W-1:0] r_out_byte;
    logic [C_FLEN_W-1:0] r_out_len;
    logic                r_out_last;

    // memory ports
    logic                fs_wr_en;
    logic [AW-1:0]       fs_wr_addr;
    logic [AW-1:0]       fs_rd_addr;
    logic [C_BYTE_W-1:0] fs_rd_data;
    logic                sl_wr_en;
    logic [LENW-1:0]     sl_rd_data;
    logic                in_acc;
    logic                go;

    // next values
    logic [SLW-1:0]      n_head, n_tail;
    logic [AW-1:0]       n_head_base, n_tail_base;
    logic                n_full;
    logic [OFFW-1:0]     n_wr_off;
    logic                n_type_match;
    logic                n_lost;
    logic [LENW-1:0]     n_rd_off;
    logic [LENW-1:0]     n_rd_total;
    t_status             n_status;
    logic [C_BYTE_W-1:0] n_byte;
    logic [C_FLEN_W-1:0] n_len;
    logic                n_last;

    // receive path intermediates
    logic [OFFW-1:0]     rx_len;
    logic                rx_tm;
    logic                rx_lost;
    logic [SLW-1:0]      tail_inc;
    logic [AW-1:0]       tail_base_inc;
    // read path intermediates
    logic [SLW-1:0]      head_inc;
    logic [AW-1:0]       head_base_inc;
    logic [LENW-1:0]     rd_total;
    logic                rd_empty;
    logic                rd_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign go            = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // frame store, addressed by slot base plus offset
    assign fs_rd_addr = r_head_base + AW'(r_rd_off);
    assign fs_wr_addr = r_tail_base + AW'(r_wr_off);

    etf_ram #(
        .WIDTH (C_BYTE_W),
        .DEPTH (SLOTS * SLOT_BYTES)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (fs_wr_en),
        .i_wr_addr (fs_wr_addr),
        .i_wr_data (r_in_byte),
        .i_rd_en   (in_acc),
        .i_rd_addr (fs_rd_addr),
        .o_rd_data (fs_rd_data)
    );

    etf_ram #(
        .WIDTH (LENW),
        .DEPTH (SLOTS)
    ) u_slot_len (
        .i_clk     (i_clk),
        .i_wr_en   (sl_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (LENW'(rx_len)),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_head),
        .o_rd_data (sl_rd_data)
    );

    // ring pointer increments with wrap
    always_comb begin
        if (r_tail == SLW'(SLOTS - 1)) begin
            tail_inc      = '0;
            tail_base_inc = '0;
        end else begin
            tail_inc      = r_tail + 1'b1;
            tail_base_inc = r_tail_base + AW'(SLOT_BYTES);
        end
        if (r_head == SLW'(SLOTS - 1)) begin
            head_inc      = '0;
            head_base_inc = '0;
        end else begin
            head_inc      = r_head + 1'b1;
            head_base_inc = r_head_base + AW'(SLOT_BYTES);
        end
    end

    // receive path: byte count, type check, loss flag
    always_comb begin
        rx_tm = r_type_match;
        if (r_wr_off == OFFW'(C_TYPE_POS)) begin
            rx_tm = (r_in_byte == C_TYPE_HI);
        end else if (r_wr_off == OFFW'(C_TYPE_POS + 1)) begin
            rx_tm = r_type_match && (r_in_byte == C_TYPE_LO);
        end
        rx_len  = (r_wr_off <= OFFW'(SLOT_BYTES)) ? r_wr_off + 1'b1 : r_wr_off;
        rx_lost = r_lost || r_full;
    end

    // read path: truncated length and last flag
    always_comb begin
        logic [CMPW-1:0] slen_w;
        logic [CMPW-1:0] lim_w;
        slen_w   = CMPW'(sl_rd_data);
        lim_w    = CMPW'(r_in_limit);
        rd_empty = !r_full && (r_tail == r_head);
        if (r_rd_off == '0) begin
            rd_total = (slen_w > lim_w) ? LENW'(lim_w) : sl_rd_data;
        end else begin
            rd_total = r_rd_total;
        end
        if (rd_total == '0) begin
            rd_last = 1'b1;
        end else begin
            rd_last = ({1'b0, r_rd_off} + 1'b1) >= {1'b0, rd_total};
        end
    end

    // update of ring state and result for the captured beat
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_head_base  = r_head_base;
        n_tail_base  = r_tail_base;
        n_full       = r_full;
        n_wr_off     = r_wr_off;
        n_type_match = r_type_match;
        n_lost       = r_lost;
        n_rd_off     = r_rd_off;
        n_rd_total   = r_rd_total;
        n_status     = ST_TAKEN;
        n_byte       = '0;
        n_len        = '0;
        n_last       = 1'b0;
        fs_wr_en     = 1'b0;
        sl_wr_en     = 1'b0;

        if (r_in_cmd == CMD_RX) begin
            fs_wr_en = go && !r_full && (r_wr_off < OFFW'(SLOT_BYTES));
            if (!r_in_last) begin
                n_wr_off     = rx_len;
                n_type_match = rx_tm;
                n_lost       = rx_lost;
            end else begin
                n_wr_off     = '0;
                n_type_match = 1'b0;
                n_lost       = 1'b0;
                if ((rx_len < OFFW'(C_MIN_FRAME)) || !rx_tm) begin
                    n_status = ST_FILTERED;
                end else if (rx_lost) begin
                    n_status = ST_FULL;
                end else if (rx_len > OFFW'(SLOT_BYTES)) begin
                    n_status = ST_OVERSIZE;
                end else begin
                    n_status    = ST_STORED;
                    n_len       = C_FLEN_W'(rx_len);
                    sl_wr_en    = go;
                    n_tail      = tail_inc;
                    n_tail_base = tail_base_inc;
                    if (tail_inc == r_head) begin
                        n_full = 1'b1;
                    end
                end
            end
        end else if (rd_empty) begin
            n_status = ST_EMPTY;
        end else begin
            n_status   = ST_READ;
            n_byte     = (rd_total == '0) ? '0 : fs_rd_data;
            n_len      = C_FLEN_W'(rd_total);
            n_last     = rd_last;
            n_rd_total = rd_total;
            if (rd_last) begin
                n_rd_off    = '0;
                n_head      = head_inc;
                n_head_base = head_base_inc;
                if (r_tail == head_inc) begin
                    n_full = 1'b0;
                end
            end else begin
                n_rd_off = r_rd_off + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_head_base  <= '0;
            r_tail_base  <= '0;
            r_full       <= 1'b0;
            r_wr_off     <= '0;
            r_type_match <= 1'b0;
            r_lost       <= 1'b0;
            r_rd_off     <= '0;
            r_rd_total   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_state      <= S_IDLE;
                        r_out_valid  <= 1'b1;
                        r_head       <= n_head;
                        r_tail       <= n_tail;
                        r_head_base  <= n_head_base;
                        r_tail_base  <= n_tail_base;
                        r_full       <= n_full;
                        r_wr_off     <= n_wr_off;
                        r_type_match <= n_type_match;
                        r_lost       <= n_lost;
                        r_rd_off     <= n_rd_off;
                        r_rd_total   <= n_rd_total;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // captured beat and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_byte  <= s_axis_tdata[C_BYTE_W-1:0];
            r_in_last  <= s_axis_tlast;
            r_in_limit <= s_axis_tdata[C_BYTE_W +: C_FLEN_W];
        end
        if (go) begin
            r_out_status <= n_status;
            r_out_byte   <= n_byte;
            r_out_len    <= n_len;
            r_out_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(C_M_DATA_W - C_BYTE_W - C_FLEN_W){1'b0}}, r_out_len, r_out_byte};

endmodule

/* hdl/etf_ram.sv */
// ----------------------------------------------------------------------------
// etf_ram - generic single write port, single read port RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module etf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
